@@ rtl/core/rbag_pkg.sv @@
`default_nettype none
package rbag_pkg;

	localparam int MAX_DIM = 4096;
	localparam int MAX_BPP = 4;
	localparam int DIM_W   = $clog2(MAX_DIM) + 1;
	localparam int BPP_W   = $clog2(MAX_BPP) + 1;
	localparam int RECT_W  = 16;
	localparam int OFS_W   = 26;
	localparam int WORD_W  = 32;
	localparam int PROD_W  = 2 * DIM_W;
	localparam int ADDR_W  = 5;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_COPY  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_PIXEL    = 2'd2,
		KIND_IDLE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_COPY  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_DIV_X,
		ST_MUL_Y,
		ST_DIV_Y,
		ST_SRC_ROW,
		ST_SRC_BPP,
		ST_DST_ROW,
		ST_DST_BPP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_SRC_W   = 3'd0,
		REG_SRC_H   = 3'd1,
		REG_DST_W   = 3'd2,
		REG_DST_H   = 3'd3,
		REG_SRC_BPP = 3'd4,
		REG_DST_BPP = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] x0;
		logic [DIM_W-1:0] y0;
		logic [DIM_W-1:0] x1;
		logic [DIM_W-1:0] y1;
	} window_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [BPP_W-1:0] sat_bpp(input logic [BPP_W-1:0] v);
		logic [BPP_W-1:0] r;
		r = v;
		if (v == '0)
			r = BPP_W'(1);
		else if (v > BPP_W'(MAX_BPP))
			r = BPP_W'(MAX_BPP);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/rbag_if.sv @@
`default_nettype none
interface rbag_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        whole_src;
	logic [15:0] src_left;
	logic [15:0] src_top;
	logic [15:0] src_right;
	logic [15:0] src_bottom;
	logic        whole_dst;
	logic [15:0] dst_left;
	logic [15:0] dst_top;
	logic [15:0] dst_right;
	logic [15:0] dst_bottom;
	logic [31:0] fill_value;

	modport source (output valid, cmd, whole_src, src_left, src_top, src_right, src_bottom,
		whole_dst, dst_left, dst_top, dst_right, dst_bottom, fill_value, input ready);
	modport sink (input valid, cmd, whole_src, src_left, src_top, src_right, src_bottom,
		whole_dst, dst_left, dst_top, dst_right, dst_bottom, fill_value, output ready);
endinterface

interface rbag_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [25:0] src_offset;
	logic [25:0] dst_offset;
	logic [31:0] fill_data;
	logic        is_fill;
	logic        last;

	modport source (output valid, kind, src_offset, dst_offset, fill_data, is_fill, last,
		input ready);
	modport sink (input valid, kind, src_offset, dst_offset, fill_data, is_fill, last,
		output ready);
endinterface
`default_nettype wire

@@ rtl/core/rbag_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit a cycle. The caller guarantees the
// quotient fits DIM_W bits (dividend < divisor << DIM_W).
module rbag_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rbag_pkg::div_req_t       req,
	output logic                          busy,
	output logic [rbag_pkg::DIM_W-1:0]    quotient
);
	import rbag_pkg::*;

	localparam int CNT_W = $clog2(DIM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] low_q;
	logic [DIM_W-1:0] quo_q;
	logic [DIM_W-1:0] dsr_q;
	logic [DIM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, low_q[DIM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CNT_W'(DIM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[PROD_W-1:DIM_W];
			low_q <= req.dividend[DIM_W-1:0];
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIM_W'(trial - {1'b0, dsr_q}) : trial[DIM_W-1:0];
			low_q <= {low_q[DIM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIM_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ rtl/core/rect_blit_address_generator_top.sv @@
`default_nettype none
// Address engine for a 2D blit. A start transaction (clear or copy) clamps the
// source and destination rectangles to their surfaces and answers "accepted"
// or "empty"; each step transaction then yields one destination pixel in
// row-major order with its byte offset, the masked fill word for a clear, or
// the nearest-neighbour source offset for a copy, and a last flag. Every
// input transaction gives exactly one result transaction. Start and idle
// transactions go straight to the output state; a clear pixel first forms
// its destination offset by row multiply and bytes-per-pixel steps, and a
// copy pixel before that scales column and row via the shared multiplier
// and restoring divider. The block takes no new transaction while one is
// in work, but accepts one while the last result waits in the output register.
// Configuration registers sit on the APB port at byte addresses 4*i.
module rect_blit_address_generator_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	rbag_cmd_if.sink                         cmds,
	rbag_res_if.source                       results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rbag_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import rbag_pkg::*;

	// Configuration registers
	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [BPP_W-1:0] src_bpp_q, dst_bpp_q;
	logic [2:0]       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= DIM_W'(1);
			src_h_q   <= DIM_W'(1);
			dst_w_q   <= DIM_W'(1);
			dst_h_q   <= DIM_W'(1);
			src_bpp_q <= BPP_W'(4);
			dst_bpp_q <= BPP_W'(4);
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_SRC_W:   src_w_q   <= pwdata[DIM_W-1:0];
				REG_SRC_H:   src_h_q   <= pwdata[DIM_W-1:0];
				REG_DST_W:   dst_w_q   <= pwdata[DIM_W-1:0];
				REG_DST_H:   dst_h_q   <= pwdata[DIM_W-1:0];
				REG_SRC_BPP: src_bpp_q <= pwdata[BPP_W-1:0];
				REG_DST_BPP: dst_bpp_q <= pwdata[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_SRC_W:   prdata = 32'(src_w_q);
			REG_SRC_H:   prdata = 32'(src_h_q);
			REG_DST_W:   prdata = 32'(dst_w_q);
			REG_DST_H:   prdata = 32'(dst_h_q);
			REG_SRC_BPP: prdata = 32'(src_bpp_q);
			REG_DST_BPP: prdata = 32'(dst_bpp_q);
			default:     prdata = '0;
		endcase
	end

	// Saturated views used by every calculation
	logic [DIM_W-1:0] ssw, ssh, dsw, dsh;
	logic [BPP_W-1:0] sbpp, dbpp;

	assign ssw  = sat_dim(src_w_q);
	assign ssh  = sat_dim(src_h_q);
	assign dsw  = sat_dim(dst_w_q);
	assign dsh  = sat_dim(dst_h_q);
	assign sbpp = sat_bpp(src_bpp_q);
	assign dbpp = sat_bpp(dst_bpp_q);

	// Clamp one rectangle to its surface; whole selects the full surface
	function automatic window_t clamp_win(input logic whole,
		input logic [RECT_W-1:0] l, input logic [RECT_W-1:0] t,
		input logic [RECT_W-1:0] r, input logic [RECT_W-1:0] b,
		input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh, output logic ok);
		window_t          w;
		logic [RECT_W-1:0] x1, y1;
		x1 = (r > RECT_W'(sw)) ? RECT_W'(sw) : r;
		y1 = (b > RECT_W'(sh)) ? RECT_W'(sh) : b;
		if (whole) begin
			w  = '{x0: '0, y0: '0, x1: sw, y1: sh};
			ok = 1'b1;
		end else begin
			w  = '{x0: l[DIM_W-1:0], y0: t[DIM_W-1:0], x1: x1[DIM_W-1:0], y1: y1[DIM_W-1:0]};
			ok = (l < x1) && (t < y1);
		end
		return w;
	endfunction

	window_t src_new, dst_new;
	logic    src_ok, dst_ok;

	always_comb begin
		src_new = clamp_win(cmds.whole_src, cmds.src_left, cmds.src_top, cmds.src_right,
			cmds.src_bottom, ssw, ssh, src_ok);
		dst_new = clamp_win(cmds.whole_dst, cmds.dst_left, cmds.dst_top, cmds.dst_right,
			cmds.dst_bottom, dsw, dsh, dst_ok);
	end

	// Job state
	mode_t            mode_q;
	window_t          src_win_q, dst_win_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic [WORD_W-1:0] fill_q;

	// Work registers of the transaction in progress
	state_t           state_q, state_d;
	kind_t            kind_q;
	logic [DIM_W-1:0] dx_q, dy_q, sx_q, sy_q;
	logic [OFS_W-1:0] acc_q, sofs_q, dofs_q;
	logic             last_q, fill_px_q;

	logic [DIM_W-1:0] dw, dh, sw, sh;
	logic             row_end, job_end;

	assign dw      = dst_win_q.x1 - dst_win_q.x0;
	assign dh      = dst_win_q.y1 - dst_win_q.y0;
	assign sw      = src_win_q.x1 - src_win_q.x0;
	assign sh      = src_win_q.y1 - src_win_q.y0;
	assign row_end = ({1'b0, col_q} + (DIM_W+1)'(1)) >= {1'b0, dw};
	assign job_end = row_end && (({1'b0, row_q} + (DIM_W+1)'(1)) >= {1'b0, dh});

	// Shared multiplier
	logic [DIM_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [OFS_W-1:0]  lin_ofs;
	logic [BPP_W-1:0]  lin_bpp;
	logic [OFS_W-1:0]  byte_ofs;

	assign mul_p    = mul_a * mul_b;
	assign byte_ofs = OFS_W'(lin_ofs * OFS_W'(lin_bpp));

	// Shared divider
	div_req_t         div_req;
	logic             div_busy;
	logic [DIM_W-1:0] div_q;

	rbag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_q)
	);

	logic accept, out_free;

	assign out_free = !results.valid || results.ready;
	assign accept   = cmds.valid && cmds.ready;

	always_comb begin
		state_d      = state_q;
		cmds.ready   = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		lin_ofs      = '0;
		lin_bpp      = dbpp;
		div_req      = '{start: 1'b0, dividend: mul_p, divisor: dw};
		case (state_q)
			ST_IDLE: begin
				cmds.ready = 1'b1;
				if (cmds.valid) begin
					if (cmds.cmd == CMD_STEP && mode_q == MODE_COPY)
						state_d = ST_MUL_X;
					else if (cmds.cmd == CMD_STEP && mode_q == MODE_CLEAR)
						state_d = ST_DST_ROW;
					else
						state_d = ST_OUT;
				end
			end
			ST_MUL_X: begin
				mul_a         = dx_q;
				mul_b         = sw;
				div_req.start = 1'b1;
				state_d       = ST_DIV_X;
			end
			ST_DIV_X: if (!div_busy) state_d = ST_MUL_Y;
			ST_MUL_Y: begin
				mul_a           = dy_q;
				mul_b           = sh;
				div_req.start   = 1'b1;
				div_req.divisor = dh;
				state_d         = ST_DIV_Y;
			end
			ST_DIV_Y: if (!div_busy) state_d = ST_SRC_ROW;
			ST_SRC_ROW: begin
				mul_a   = sy_q + src_win_q.y0;
				mul_b   = ssw;
				state_d = ST_SRC_BPP;
			end
			ST_SRC_BPP: begin
				lin_ofs = acc_q + OFS_W'(sx_q) + OFS_W'(src_win_q.x0);
				lin_bpp = sbpp;
				state_d = ST_DST_ROW;
			end
			ST_DST_ROW: begin
				mul_a   = dy_q + dst_win_q.y0;
				mul_b   = dsw;
				state_d = ST_DST_BPP;
			end
			ST_DST_BPP: begin
				lin_ofs = acc_q + OFS_W'(dx_q) + OFS_W'(dst_win_q.x0);
				state_d = ST_OUT;
			end
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Job state: update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			src_win_q <= '0;
			dst_win_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			if (cmds.cmd == CMD_CLEAR || cmds.cmd == CMD_COPY) begin
				if (cmds.cmd == CMD_COPY)
					src_win_q <= src_new;
				// the destination window is not taken if the source is empty
				if (cmds.cmd == CMD_CLEAR || src_ok)
					dst_win_q <= dst_new;
				col_q  <= '0;
				row_q  <= '0;
				fill_q <= cmds.fill_value;
				if ((cmds.cmd == CMD_COPY && !src_ok) || !dst_ok)
					mode_q <= MODE_IDLE;
				else
					mode_q <= (cmds.cmd == CMD_CLEAR) ? MODE_CLEAR : MODE_COPY;
			end else if (cmds.cmd == CMD_STEP && mode_q != MODE_IDLE) begin
				// advance the raster position
				if (job_end) begin
					mode_q <= MODE_IDLE;
					col_q  <= '0;
					row_q  <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + DIM_W'(1);
				end
			end
		end
	end

	// Work registers of the transaction in progress
	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q      <= col_q;
			dy_q      <= row_q;
			last_q    <= job_end;
			fill_px_q <= mode_q == MODE_CLEAR;
			sofs_q    <= '0;
			case (cmds.cmd)
				CMD_CLEAR, CMD_COPY:
					kind_q <= ((cmds.cmd == CMD_COPY && !src_ok) || !dst_ok) ?
						KIND_EMPTY : KIND_ACCEPTED;
				CMD_STEP:
					kind_q <= (mode_q != MODE_IDLE) ? KIND_PIXEL : KIND_IDLE;
				default:
					kind_q <= KIND_IDLE;
			endcase
		end
		if (state_q == ST_DIV_X && !div_busy)
			sx_q <= div_q;
		if (state_q == ST_DIV_Y && !div_busy)
			sy_q <= div_q;
		if (state_q == ST_SRC_ROW || state_q == ST_DST_ROW)
			acc_q <= mul_p[OFS_W-1:0];
		if (state_q == ST_SRC_BPP)
			sofs_q <= byte_ofs;
		if (state_q == ST_DST_BPP)
			dofs_q <= byte_ofs;
	end

	// Output register: hold the result until the sink takes it
	logic [WORD_W-1:0] fill_mask;

	always_comb begin
		case (dbpp)
			BPP_W'(1): fill_mask = 32'h0000_00FF;
			BPP_W'(2): fill_mask = 32'h0000_FFFF;
			BPP_W'(3): fill_mask = 32'h00FF_FFFF;
			default:   fill_mask = 32'hFFFF_FFFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results.valid <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			results.valid <= 1'b1;
		else if (results.ready)
			results.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			results.kind <= kind_q;
			if (kind_q == KIND_PIXEL) begin
				results.src_offset <= fill_px_q ? '0 : sofs_q;
				results.dst_offset <= dofs_q;
				results.fill_data  <= fill_px_q ? (fill_q & fill_mask) : '0;
				results.is_fill    <= fill_px_q;
				results.last       <= last_q;
			end else begin
				results.src_offset <= '0;
				results.dst_offset <= '0;
				results.fill_data  <= '0;
				results.is_fill    <= 1'b0;
				results.last       <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
